// ===== hw/rtl/lamp_mode_and_current_trim_core_assert.svh =====
// Assertion macros for the lamp mode and current trim RTL.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef LAMP_MODE_AND_CURRENT_TRIM_CORE_ASSERT_SVH
`define LAMP_MODE_AND_CURRENT_TRIM_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define LMCT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define LMCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LMCT_ASSERT_IMPL(lbl, ante, cons, msg)
`define LMCT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/lmct_pkg.sv =====
package lmct_pkg;

  // Field widths.
  localparam int unsigned TargetW = 12;
  localparam int unsigned DacW    = 8;
  localparam int unsigned CountW  = 8;
  localparam int unsigned ShuntW  = 10;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;

  // Regulation and trim limits.
  localparam logic [TargetW-1:0] TARGET_MAX = 12'hfff;
  localparam logic [TargetW-1:0] TARGET_MIN = 12'd10;
  localparam logic [DacW-1:0]    DAC_LO     = 8'd1;
  localparam logic [DacW-1:0]    DAC_HI     = 8'd255;
  localparam logic [DacW-1:0]    DAC_RESET  = 8'd5;
  localparam logic [CountW-1:0]  COUNT_MAX  = 8'd255;

  // The mode machine settles in this many passes per tick.
  localparam int unsigned MODE_PASSES = 4;

  // Register reset values.
  localparam logic [TargetW-1:0] UV_TARGET_RESET  = 12'd377;
  localparam logic [TargetW-1:0] WLO_TARGET_RESET = 12'd1280;
  localparam logic [TargetW-1:0] WHI_TARGET_RESET = 12'd350;
  localparam logic [DacW-1:0]    UV_DAC_RESET     = 8'd150;
  localparam logic [DacW-1:0]    WLO_DAC_RESET    = 8'd180;
  localparam logic [DacW-1:0]    WHI_DAC_RESET    = 8'd160;
  localparam logic [CountW-1:0]  LONG_HOLD_RESET  = 8'd20;
  localparam logic [CountW-1:0]  IDLE_LIMIT_RESET = 8'd50;

  // Register indexes.
  localparam logic [2:0] REG_UV_TARGET  = 3'd0;
  localparam logic [2:0] REG_WLO_TARGET = 3'd1;
  localparam logic [2:0] REG_WHI_TARGET = 3'd2;
  localparam logic [2:0] REG_UV_DAC     = 3'd3;
  localparam logic [2:0] REG_WLO_DAC    = 3'd4;
  localparam logic [2:0] REG_WHI_DAC    = 3'd5;
  localparam logic [2:0] REG_LONG_HOLD  = 3'd6;
  localparam logic [2:0] REG_IDLE_LIMIT = 3'd7;

  // Lamp mode codes as seen on the result.
  localparam logic [1:0] LAMP_OFF = 2'd0;
  localparam logic [1:0] LAMP_UV  = 2'd1;
  localparam logic [1:0] LAMP_WLO = 2'd2;
  localparam logic [1:0] LAMP_WHI = 2'd3;

  // Store entries of the lit modes.
  localparam logic [1:0] IDX_UV  = 2'd0;
  localparam logic [1:0] IDX_WLO = 2'd1;
  localparam logic [1:0] IDX_WHI = 2'd2;

  typedef enum logic [3:0] {
    MODE_OFF = 4'b0001,
    MODE_UV  = 4'b0010,
    MODE_WLO = 4'b0100,
    MODE_WHI = 4'b1000
  } mode_t;

  typedef struct packed {
    logic              uv_switch;
    logic              white_switch;
    logic              plus_switch;
    logic              minus_switch;
    logic              mem_switch;
    logic [ShuntW-1:0] shunt_current;
  } item_t;

  typedef struct packed {
    logic [DacW-1:0]    dac_value;
    logic [1:0]         lamp_mode;
    logic               power_off;
    logic               save_pulse;
    logic [TargetW-1:0] active_target;
  } result_t;

  typedef struct packed {
    logic [TargetW-1:0] uv_target_init;
    logic [TargetW-1:0] white_low_target_init;
    logic [TargetW-1:0] white_high_target_init;
    logic [DacW-1:0]    uv_dac_init;
    logic [DacW-1:0]    white_low_dac_init;
    logic [DacW-1:0]    white_high_dac_init;
    logic [CountW-1:0]  long_hold_ticks;
    logic [CountW-1:0]  idle_limit_ticks;
  } cfg_t;

  // One register write, seen by the stores that load on it.
  typedef struct packed {
    logic               en;
    logic [2:0]         idx;
    logic [TargetW-1:0] data;
  } cfg_wr_t;

  // Qualified switch events of one tick.
  typedef struct packed {
    logic uv_level;
    logic white_level;
    logic uv_edge;
    logic white_edge;
    logic white_long;
    logic plus_trim;
    logic minus_trim;
    logic mem_edge;
  } sw_qual_t;

  function automatic logic [CountW-1:0] sat_inc(logic [CountW-1:0] v);
    return (v == COUNT_MAX) ? v : v + 8'd1;
  endfunction

  function automatic logic [1:0] lamp_code(mode_t m);
    logic [1:0] code;
    case (m)
      MODE_UV:  code = LAMP_UV;
      MODE_WLO: code = LAMP_WLO;
      MODE_WHI: code = LAMP_WHI;
      default:  code = LAMP_OFF;
    endcase
    return code;
  endfunction

  function automatic logic [1:0] store_idx(mode_t m);
    logic [1:0] idx;
    case (m)
      MODE_WLO: idx = IDX_WLO;
      MODE_WHI: idx = IDX_WHI;
      default:  idx = IDX_UV;
    endcase
    return idx;
  endfunction

endpackage

// ===== hw/rtl/lmct_cfg.sv =====
module lmct_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lmct_pkg::AddrW-1:0]   paddr,
  input  logic [lmct_pkg::DataW-1:0]   pwdata,
  output logic [lmct_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  output lmct_pkg::cfg_t               cfg,
  output lmct_pkg::cfg_wr_t            cfg_wr
);
  import lmct_pkg::*;

  logic       wr_en;
  logic [2:0] idx;

  // A write transaction completes in its access cycle; there are no wait states.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[AddrW-1:2];

  // Store loads follow every target or start value write.
  assign cfg_wr.en   = wr_en;
  assign cfg_wr.idx  = idx;
  assign cfg_wr.data = pwdata[TargetW-1:0];

  // Register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.uv_target_init         <= UV_TARGET_RESET;
      cfg.white_low_target_init  <= WLO_TARGET_RESET;
      cfg.white_high_target_init <= WHI_TARGET_RESET;
      cfg.uv_dac_init            <= UV_DAC_RESET;
      cfg.white_low_dac_init     <= WLO_DAC_RESET;
      cfg.white_high_dac_init    <= WHI_DAC_RESET;
      cfg.long_hold_ticks        <= LONG_HOLD_RESET;
      cfg.idle_limit_ticks       <= IDLE_LIMIT_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_UV_TARGET:  cfg.uv_target_init         <= pwdata[TargetW-1:0];
        REG_WLO_TARGET: cfg.white_low_target_init  <= pwdata[TargetW-1:0];
        REG_WHI_TARGET: cfg.white_high_target_init <= pwdata[TargetW-1:0];
        REG_UV_DAC:     cfg.uv_dac_init            <= pwdata[DacW-1:0];
        REG_WLO_DAC:    cfg.white_low_dac_init     <= pwdata[DacW-1:0];
        REG_WHI_DAC:    cfg.white_high_dac_init    <= pwdata[DacW-1:0];
        REG_LONG_HOLD:  cfg.long_hold_ticks        <= pwdata[CountW-1:0];
        REG_IDLE_LIMIT: cfg.idle_limit_ticks       <= pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  // Read data, zero extended.
  always_comb begin
    case (idx)
      REG_UV_TARGET:  prdata = {{(DataW-TargetW){1'b0}}, cfg.uv_target_init};
      REG_WLO_TARGET: prdata = {{(DataW-TargetW){1'b0}}, cfg.white_low_target_init};
      REG_WHI_TARGET: prdata = {{(DataW-TargetW){1'b0}}, cfg.white_high_target_init};
      REG_UV_DAC:     prdata = {{(DataW-DacW){1'b0}}, cfg.uv_dac_init};
      REG_WLO_DAC:    prdata = {{(DataW-DacW){1'b0}}, cfg.white_low_dac_init};
      REG_WHI_DAC:    prdata = {{(DataW-DacW){1'b0}}, cfg.white_high_dac_init};
      REG_LONG_HOLD:  prdata = {{(DataW-CountW){1'b0}}, cfg.long_hold_ticks};
      REG_IDLE_LIMIT: prdata = {{(DataW-CountW){1'b0}}, cfg.idle_limit_ticks};
      default:        prdata = '0;
    endcase
  end

endmodule

// ===== hw/rtl/lmct_switch.sv =====
module lmct_switch (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  lmct_pkg::item_t             item,
  input  logic [lmct_pkg::CountW-1:0] long_hold_ticks,
  output lmct_pkg::sw_qual_t          qual
);
  import lmct_pkg::*;

  // Switch order: uv, white, plus, minus, mem.
  localparam int unsigned NumSw   = 5;
  localparam int unsigned NumHold = NumSw - 1;

  logic [NumSw-1:0]  level;
  logic [NumSw-1:0]  press;
  logic [NumSw-1:0]  switch_prev;
  logic [CountW-1:0] hold_count [NumHold];
  logic [CountW-1:0] hold_count_next [NumHold];
  logic [NumHold-1:0] held;

  assign level = {item.mem_switch, item.minus_switch, item.plus_switch,
                  item.white_switch, item.uv_switch};
  assign press = level & ~switch_prev;

  // Hold counters for every switch but UV; a long hold needs count above the limit.
  always_comb begin
    for (int j = 0; j < NumHold; j++) begin
      hold_count_next[j] = level[j+1] ? sat_inc(hold_count[j]) : '0;
      held[j]            = level[j+1] && (hold_count_next[j] > long_hold_ticks);
    end
  end

  assign qual.uv_level    = level[0];
  assign qual.white_level = level[1];
  assign qual.uv_edge     = press[0];
  assign qual.white_edge  = press[1];
  assign qual.white_long  = held[0];
  assign qual.plus_trim   = press[2] || held[1];
  assign qual.minus_trim  = press[3] || held[2];
  assign qual.mem_edge    = press[4];

  // History advances once per tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      switch_prev <= '0;
      for (int j = 0; j < NumHold; j++) begin
        hold_count[j] <= '0;
      end
    end else if (step) begin
      switch_prev <= level;
      hold_count  <= hold_count_next;
    end
  end

endmodule

// ===== hw/rtl/lmct_ctrl.sv =====
`include "lamp_mode_and_current_trim_core_assert.svh"

module lmct_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [lmct_pkg::ShuntW-1:0] shunt_current,
  input  lmct_pkg::sw_qual_t          qual,
  input  logic [lmct_pkg::CountW-1:0] idle_limit_ticks,
  input  lmct_pkg::cfg_wr_t           cfg_wr,
  output lmct_pkg::result_t           result
);
  import lmct_pkg::*;

  localparam int unsigned NumModes = 3;

  mode_t              mode_q;
  logic [DacW-1:0]    dac_q;
  logic [TargetW-1:0] target_q [NumModes];
  logic [DacW-1:0]    start_q [NumModes];
  logic               pend_uv_q;
  logic               pend_white_q;
  logic [CountW-1:0]  idle_count_q;
  logic               power_off_q;

  logic [1:0]         k;
  logic               lit;
  logic [TargetW-1:0] cur_target;
  logic [TargetW-1:0] shunt_ext;
  logic [DacW-1:0]    dac_step;
  logic [TargetW-1:0] target_next [NumModes];
  logic [DacW-1:0]    start_next [NumModes];
  logic [TargetW-1:0] target_load [NumModes];
  logic [DacW-1:0]    start_load [NumModes];
  logic               save;

  mode_t              mode_next;
  logic [DacW-1:0]    dac_next;
  logic               pend_uv_next;
  logic               pend_white_next;
  logic               long_v;
  logic [CountW-1:0]  idle_count_next;
  logic               power_off_next;

  assign k          = store_idx(mode_q);
  assign lit        = (mode_q != MODE_OFF);
  assign cur_target = target_q[k];
  assign shunt_ext  = {{(TargetW-ShuntW){1'b0}}, shunt_current};

  // Regulation: the loop is inverted, so a low current steps the DAC down.
  always_comb begin
    dac_step = dac_q;
    if (lit) begin
      if (shunt_ext < cur_target) begin
        if (dac_q > DAC_LO) begin
          dac_step = dac_q - 8'd1;
        end
      end else if (shunt_ext > cur_target) begin
        if (dac_q < DAC_HI) begin
          dac_step = dac_q + 8'd1;
        end
      end
    end
  end

  // Trim and memorize: plus wins over minus, and mem acts only without a trim.
  always_comb begin
    target_next = target_q;
    start_next  = start_q;
    save        = 1'b0;
    if (lit) begin
      if (qual.plus_trim) begin
        if (cur_target < TARGET_MAX) begin
          target_next[k] = cur_target + 12'd1;
        end
      end else if (qual.minus_trim) begin
        if (cur_target > TARGET_MIN) begin
          target_next[k] = cur_target - 12'd1;
        end
      end else if (qual.mem_edge) begin
        start_next[k] = dac_step;
        save          = 1'b1;
      end
    end
  end

  // Store contents for the next cycle: the tick's update, then any register write.
  always_comb begin
    if (step) begin
      target_load = target_next;
      start_load  = start_next;
    end else begin
      target_load = target_q;
      start_load  = start_q;
    end
    if (cfg_wr.en) begin
      case (cfg_wr.idx)
        REG_UV_TARGET:  target_load[IDX_UV]  = cfg_wr.data;
        REG_WLO_TARGET: target_load[IDX_WLO] = cfg_wr.data;
        REG_WHI_TARGET: target_load[IDX_WHI] = cfg_wr.data;
        REG_UV_DAC:     start_load[IDX_UV]   = cfg_wr.data[DacW-1:0];
        REG_WLO_DAC:    start_load[IDX_WLO]  = cfg_wr.data[DacW-1:0];
        REG_WHI_DAC:    start_load[IDX_WHI]  = cfg_wr.data[DacW-1:0];
        default: ;
      endcase
    end
  end

  // Mode machine, settled over a fixed number of passes per tick.
  always_comb begin
    mode_next       = mode_q;
    dac_next        = dac_step;
    pend_uv_next    = qual.uv_level && (pend_uv_q || qual.uv_edge);
    pend_white_next = qual.white_level && (pend_white_q || qual.white_edge);
    long_v          = qual.white_long;
    idle_count_next = sat_inc(idle_count_q);
    power_off_next  = power_off_q;
    for (int p = 0; p < MODE_PASSES; p++) begin
      if (mode_next == MODE_OFF) begin
        if (pend_uv_next) begin
          pend_uv_next = 1'b0;
          mode_next    = MODE_UV;
          dac_next     = start_next[IDX_UV];
        end else if (pend_white_next) begin
          pend_white_next = 1'b0;
          mode_next       = MODE_WLO;
          dac_next        = start_next[IDX_WLO];
        end else if (long_v) begin
          long_v    = 1'b0;
          mode_next = MODE_WHI;
          dac_next  = start_next[IDX_WHI];
        end
        if (idle_count_next > idle_limit_ticks) begin
          power_off_next = 1'b1;
        end
      end else begin
        idle_count_next = '0;
        if (pend_uv_next || pend_white_next) begin
          pend_uv_next    = 1'b0;
          pend_white_next = 1'b0;
          mode_next       = MODE_OFF;
        end else if (mode_next == MODE_WLO && long_v) begin
          long_v    = 1'b0;
          mode_next = MODE_WHI;
        end
      end
    end
  end

  assign result.dac_value     = dac_step;
  assign result.lamp_mode     = lamp_code(mode_next);
  assign result.power_off     = power_off_next;
  assign result.save_pulse    = save;
  assign result.active_target = lit ? cur_target : '0;

  // State update per tick; the stores also take register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_q        <= MODE_OFF;
      dac_q         <= DAC_RESET;
      target_q[0]   <= UV_TARGET_RESET;
      target_q[1]   <= WLO_TARGET_RESET;
      target_q[2]   <= WHI_TARGET_RESET;
      start_q[0]    <= UV_DAC_RESET;
      start_q[1]    <= WLO_DAC_RESET;
      start_q[2]    <= WHI_DAC_RESET;
      pend_uv_q     <= 1'b0;
      pend_white_q  <= 1'b0;
      idle_count_q  <= '0;
      power_off_q   <= 1'b0;
    end else begin
      target_q <= target_load;
      start_q  <= start_load;
      if (step) begin
        mode_q       <= mode_next;
        dac_q        <= dac_next;
        pend_uv_q    <= pend_uv_next;
        pend_white_q <= pend_white_next;
        idle_count_q <= idle_count_next;
        power_off_q  <= power_off_next;
      end
    end
  end

  // The power-off request is sticky until reset.
  `LMCT_ASSERT_NEXT(a_power_off_sticky, power_off_q, power_off_q, "power-off request dropped")
  // Any tick that starts lit leaves the idle counter cleared.
  `LMCT_ASSERT_NEXT(a_idle_clear_lit, step && lit, idle_count_q == '0, "idle count not cleared")
  // A tick that starts off regulates nothing and never saves.
  `LMCT_ASSERT_IMPL(a_off_quiet, !lit, !save && result.active_target == '0, "off tick active")

endmodule

// ===== hw/rtl/lamp_mode_and_current_trim_core.sv =====
// Lamp mode and current trim core. Each item is one 100 ms tick carrying five switch
// levels and a shunt current sample; each accepted item yields exactly one result with
// the DAC code, lamp mode, power-off request, save pulse and active target. The core
// takes one item per clock cycle while the result side is not stalled: an item waits in
// the input register, where switch qualification, regulation, trim and the mode machine
// are evaluated combinationally, and its result is loaded into the output register when
// that register is free or being drained. Registers are written over the APB port with
// no wait states; target and start DAC writes also load the live store entry, so they
// belong to idle periods.
module lamp_mode_and_current_trim_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  lmct_pkg::item_t            item,
  output logic                       result_valid,
  input  logic                       result_ready,
  output lmct_pkg::result_t          result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lmct_pkg::AddrW-1:0] paddr,
  input  logic [lmct_pkg::DataW-1:0] pwdata,
  output logic [lmct_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import lmct_pkg::*;

  logic     s1_valid;
  item_t    s1_item;
  logic     advance;
  cfg_t     cfg;
  cfg_wr_t  cfg_wr;
  sw_qual_t qual;
  result_t  ctrl_result;

  // The input register moves on whenever the output register is free or being drained.
  assign advance    = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || advance;

  lmct_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .cfg_wr  (cfg_wr)
  );

  lmct_switch u_switch (
    .clk             (clk),
    .rst             (rst),
    .step            (advance),
    .item            (s1_item),
    .long_hold_ticks (cfg.long_hold_ticks),
    .qual            (qual)
  );

  lmct_ctrl u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .step             (advance),
    .shunt_current    (s1_item.shunt_current),
    .qual             (qual),
    .idle_limit_ticks (cfg.idle_limit_ticks),
    .cfg_wr           (cfg_wr),
    .result           (ctrl_result)
  );

  // Input and output register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_ready) begin
        s1_valid <= item_valid;
      end
      if (advance) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers load on an input transaction and on each tick that completes.
  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      s1_item <= item;
    end
    if (advance) begin
      result <= ctrl_result;
    end
  end

endmodule
